/* rtl/core/concentric_disk_sample_macros.svh */
// ----------------------------------------------------------------------------
// Concentric disk sampler assertion macros
// Shared property wrappers, clocked on clk.
// ----------------------------------------------------------------------------
`ifndef CONCENTRIC_DISK_SAMPLE_MACROS_SVH
`define CONCENTRIC_DISK_SAMPLE_MACROS_SVH

// checked only outside reset
`define CDS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked on every edge, reset included
`define CDS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/core/cds_pkg.sv */
// ----------------------------------------------------------------------------
// cds_pkg
// Shared types, constants and helpers of the concentric disk sampler.
// ----------------------------------------------------------------------------
package cds_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int Q_BITS          = 17;  // quotient width, |q| <= 1.0 eighth
  localparam int T_BITS          = 19;  // angle, Q3.16 eighths
  localparam int Z_BITS          = 20;
  localparam int X0_BITS         = 31;
  localparam int CW              = 34;  // CORDIC datapath width
  localparam int CORDIC_STEPS    = 16;
  localparam int QUEUE_DEPTH     = 4;
  localparam int OUT_BITS        = 16;
  localparam logic [29:0] GAIN_Q30 = 30'd652032874;

  // accept edge to strobe cycle
  localparam int LATENCY = 36;

  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  typedef struct packed {
    logic                       origin;
    logic [1:0]                 quad;
    logic signed [Z_BITS-1:0]   z;
    logic [X0_BITS-1:0]         x0;
  } item_t;

  // arctangent of 2^-i in Q.16 eighths of a turn
  function automatic logic signed [Z_BITS-1:0] atan_q16(input logic [3:0] idx);
    logic signed [Z_BITS-1:0] a;
    case (idx)
      4'd0:    a = 20'sd65536;
      4'd1:    a = 20'sd38688;
      4'd2:    a = 20'sd20442;
      4'd3:    a = 20'sd10377;
      4'd4:    a = 20'sd5208;
      4'd5:    a = 20'sd2607;
      4'd6:    a = 20'sd1304;
      4'd7:    a = 20'sd652;
      4'd8:    a = 20'sd326;
      4'd9:    a = 20'sd163;
      4'd10:   a = 20'sd81;
      4'd11:   a = 20'sd41;
      4'd12:   a = 20'sd20;
      4'd13:   a = 20'sd10;
      4'd14:   a = 20'sd5;
      4'd15:   a = 20'sd3;
      default: a = '0;
    endcase
    return a;
  endfunction

  // round half up, drop 15 fraction bits, clamp to Q1.15
  function automatic logic signed [OUT_BITS-1:0] sat_q15(input logic signed [CW-1:0] v);
    logic signed [CW:0] sum;
    logic signed [CW:0] sh;
    logic signed [OUT_BITS-1:0] o;
    sum = {v[CW-1], v} + (CW+1)'(1 << 14);
    sh  = sum >>> 15;
    if (sh > (CW+1)'(32767))
      o = 16'sh7FFF;
    else if (sh < -(CW+1)'(32768))
      o = 16'sh8000;
    else
      o = sh[OUT_BITS-1:0];
    return o;
  endfunction

endpackage

/* rtl/core/cds_front.sv */
// ----------------------------------------------------------------------------
// cds_front
// Scales and classifies samples, divides the minor coordinate by the radius
// in a pipelined restoring divider, and forms the reduced angle.
// ----------------------------------------------------------------------------
module cds_front #(
  parameter int SAMPLE_BITS = cds_pkg::SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  logic [SAMPLE_BITS-1:0] sample_u,
  input  logic [SAMPLE_BITS-1:0] sample_v,
  output logic                   push,
  output cds_pkg::item_t         item
);

  localparam int N  = SAMPLE_BITS;
  localparam int SW = N + 2;
  localparam int MW = N + 1;
  localparam int QW = cds_pkg::Q_BITS;
  localparam int DW = N + QW;
  localparam int TW = cds_pkg::T_BITS;
  localparam int NS = QW;  // one divider stage per quotient bit

  logic signed [SW-1:0] sx, sy, r_s, num_s;
  logic signed [SW:0]   sum_xy;
  logic [1:0]           base;
  logic                 sub;
  logic [MW-1:0]        r_mag, num_mag;

  assign sx     = $signed({1'b0, sample_u, 1'b0}) - $signed({2'b01, {N{1'b0}}});
  assign sy     = $signed({1'b0, sample_v, 1'b0}) - $signed({2'b01, {N{1'b0}}});
  assign sum_xy = {sx[SW-1], sx} + {sy[SW-1], sy};

  // wedge selection; base is in quarter turns
  always_comb begin
    if (sum_xy >= 0) begin
      if (sx > sy) begin
        r_s = sx;  num_s = sy; base = cds_pkg::QUAD_0; sub = 1'b0;
      end else begin
        r_s = sy;  num_s = sx; base = cds_pkg::QUAD_1; sub = 1'b1;
      end
    end else begin
      if (sx <= sy) begin
        r_s = -sx; num_s = sy; base = cds_pkg::QUAD_2; sub = 1'b1;
      end else begin
        r_s = -sy; num_s = sx; base = cds_pkg::QUAD_3; sub = 1'b0;
      end
    end
  end

  logic signed [SW-1:0] num_abs;
  assign num_abs = num_s[SW-1] ? -num_s : num_s;
  assign num_mag = num_abs[MW-1:0];
  assign r_mag   = r_s[MW-1:0];

  // pipeline: index 0 is the classify register, 1..NS the divider stages
  logic            vld    [NS+1];
  logic [DW-1:0]   rem    [NS+1];
  logic [QW-1:0]   quo    [NS+1];
  logic [MW-1:0]   rad    [NS+1];
  logic [1:0]      bse    [NS+1];
  logic            minus  [NS+1];
  logic            orig   [NS+1];
  logic [cds_pkg::X0_BITS-1:0] x0 [NS+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= accept;
    end
    rem[0]   <= {num_mag, {QW-1{1'b0}}};
    quo[0]   <= '0;
    rad[0]   <= r_mag;
    bse[0]   <= base;
    minus[0] <= num_s[SW-1] ^ sub;
    orig[0]  <= (r_mag == '0);
    x0[0]    <= '0;
  end

  // radius to Q1.30 and the CORDIC gain
  logic [30:0] r_q30;
  logic [60:0] prod;
  generate
    if (N <= 30) begin : g_up
      assign r_q30 = 31'(rad[0]) << (30 - N);
    end else begin : g_dn
      assign r_q30 = rad[0][N:N-30];
    end
  endgenerate
  assign prod = {30'b0, r_q30} * {31'b0, cds_pkg::GAIN_Q30};

  genvar s;
  generate
    for (s = 1; s <= NS; s++) begin : g_div
      localparam int B = NS - s;
      logic [DW-1:0] shifted;
      logic          ge;
      assign shifted = {{(QW-1){1'b0}}, rad[s-1]} << B;
      assign ge      = rem[s-1] >= shifted;
      always_ff @(posedge clk) begin
        if (rst) begin
          vld[s] <= 1'b0;
        end else begin
          vld[s] <= vld[s-1];
        end
        rem[s]   <= ge ? rem[s-1] - shifted : rem[s-1];
        quo[s]   <= quo[s-1] | ({{(QW-1){1'b0}}, ge} << B);
        rad[s]   <= rad[s-1];
        bse[s]   <= bse[s-1];
        minus[s] <= minus[s-1];
        orig[s]  <= orig[s-1];
        x0[s]    <= (s == 1) ? prod[60:30] : x0[s-1];
      end
    end
  endgenerate

  // angle in eighths, then split into quarter turns and a residual
  logic [TW-1:0]    q_ext, t, t_off;
  logic signed [TW+1:0] z_raw, z_red;
  logic [1:0]       quad;

  assign q_ext = {{(TW-QW){1'b0}}, quo[NS]};
  assign t     = {bse[NS], {(TW-2){1'b0}}} + (minus[NS] ? (~q_ext + 1'b1) : q_ext);
  assign t_off = t + TW'(1 << 16);
  assign quad  = t_off[TW-1:TW-2];
  assign z_raw = $signed({2'b00, t}) - $signed({2'b00, quad, {(TW-2){1'b0}}});
  assign z_red = (z_raw >= $signed((TW+2)'(1 << 18))) ? z_raw - $signed((TW+2)'(1 << 19))
                                                      : z_raw;

  assign push        = vld[NS];
  assign item.origin = orig[NS];
  assign item.quad   = quad;
  assign item.z      = z_red[cds_pkg::Z_BITS-1:0];
  assign item.x0     = x0[NS];

endmodule

/* rtl/core/cds_queue.sv */
// ----------------------------------------------------------------------------
// cds_queue
// Small register FIFO between the angle front end and the CORDIC back end.
// ----------------------------------------------------------------------------
module cds_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  cds_pkg::item_t push_item,
  input  logic           pop,
  output logic           not_empty,
  output logic           full,
  output cds_pkg::item_t head
);

  localparam int D  = cds_pkg::QUEUE_DEPTH;
  localparam int PW = $clog2(D);

  cds_pkg::item_t mem [D];
  logic [PW-1:0]  wr_ptr, rd_ptr;
  logic [PW:0]    count;
  logic           do_pop;

  assign not_empty = (count != '0);
  assign full      = (count == (PW+1)'(D));
  assign head      = mem[rd_ptr];
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (PW+1)'(push) - (PW+1)'(do_pop);
    end
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

/* rtl/core/cds_back.sv */
// ----------------------------------------------------------------------------
// cds_back
// 16-stage CORDIC rotation pipeline, quadrant restore and Q1.15 output.
// ----------------------------------------------------------------------------
module cds_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  cds_pkg::item_t        in_item,
  output logic                  strobe,
  output logic signed [15:0]    disk_x,
  output logic signed [15:0]    disk_y
);

  localparam int CW = cds_pkg::CW;
  localparam int ZW = cds_pkg::Z_BITS;
  localparam int NS = cds_pkg::CORDIC_STEPS;

  logic                 vld  [NS];
  logic signed [CW-1:0] cx   [NS];
  logic signed [CW-1:0] cy   [NS];
  logic signed [ZW-1:0] cz   [NS];
  logic [1:0]           quad [NS];
  logic                 orig [NS];

  genvar i;
  generate
    for (i = 0; i < NS; i++) begin : g_rot
      logic                 pv, po;
      logic [1:0]           pq;
      logic signed [CW-1:0] px, py, dx, dy;
      logic signed [ZW-1:0] pz, at;
      if (i == 0) begin : g_src
        assign pv = in_valid;
        assign px = $signed({{(CW-cds_pkg::X0_BITS){1'b0}}, in_item.x0});
        assign py = '0;
        assign pz = in_item.z;
        assign pq = in_item.quad;
        assign po = in_item.origin;
      end else begin : g_chain
        assign pv = vld[i-1];
        assign px = cx[i-1];
        assign py = cy[i-1];
        assign pz = cz[i-1];
        assign pq = quad[i-1];
        assign po = orig[i-1];
      end
      assign dx = py >>> i;
      assign dy = px >>> i;
      assign at = cds_pkg::atan_q16(4'(i));
      always_ff @(posedge clk) begin
        if (rst) begin
          vld[i] <= 1'b0;
        end else begin
          vld[i] <= pv;
        end
        if (pz >= 0) begin
          cx[i] <= px - dx;
          cy[i] <= py + dy;
          cz[i] <= pz - at;
        end else begin
          cx[i] <= px + dx;
          cy[i] <= py - dy;
          cz[i] <= pz + at;
        end
        quad[i] <= pq;
        orig[i] <= po;
      end
    end
  endgenerate

  logic signed [CW-1:0] ox, oy, fx, fy;
  assign fx = cx[NS-1];
  assign fy = cy[NS-1];

  always_comb begin
    case (quad[NS-1])
      cds_pkg::QUAD_1: begin ox = -fy; oy = fx;  end
      cds_pkg::QUAD_2: begin ox = -fx; oy = -fy; end
      cds_pkg::QUAD_3: begin ox = fy;  oy = -fx; end
      default:         begin ox = fx;  oy = fy;  end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= vld[NS-1];
    end
    disk_x <= orig[NS-1] ? '0 : cds_pkg::sat_q15(ox);
    disk_y <= orig[NS-1] ? '0 : cds_pkg::sat_q15(oy);
  end

endmodule

/* rtl/core/concentric_disk_sample.sv */
// ----------------------------------------------------------------------------
// concentric_disk_sample
// Concentric square-to-disk mapping of uniform sample pairs, fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   A sample pair (sample_u, sample_v, unsigned Q0.SAMPLE_BITS) is taken at a
//   rising edge with start high and busy low. One transaction comes back for
//   each: disk_x, disk_y (signed Q1.15, saturating) valid for the single
//   cycle in which strobe is high.
//   Path: a classify register loaded at the accepting edge, 17 divider
//   stages, 1 queue slot, 16 CORDIC stages and 1 output register lie between
//   an accepted pair and its strobe.
//   Throughput: one pair per cycle. The back end drains the queue every
//   cycle, so the queue never holds more than one entry and busy stays low.
//   Results are delivered in order of acceptance. The receiver cannot stall
//   the block and must take each result in its strobe cycle.
//   Reset (rst, synchronous) empties the queue and drops all pairs in flight;
//   no strobe follows a reset edge until new pairs arrive.
// ----------------------------------------------------------------------------
module concentric_disk_sample #(
  parameter int SAMPLE_BITS = cds_pkg::SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [SAMPLE_BITS-1:0] sample_u,
  input  logic [SAMPLE_BITS-1:0] sample_v,
  output logic                   strobe,
  output logic signed [15:0]     disk_x,
  output logic signed [15:0]     disk_y
);

  logic           accept, push, not_empty, full;
  cds_pkg::item_t push_item, head;

  assign accept = start && !busy;
  assign busy   = full;

  cds_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .sample_u (sample_u),
    .sample_v (sample_v),
    .push     (push),
    .item     (push_item)
  );

  cds_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (1'b1),
    .not_empty (not_empty),
    .full      (full),
    .head      (head)
  );

  cds_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (not_empty),
    .in_item  (head),
    .strobe   (strobe),
    .disk_x   (disk_x),
    .disk_y   (disk_y)
  );

endmodule

/* rtl/core/cds_checker.sv */
// ----------------------------------------------------------------------------
// cds_checker
// Port-level checks of the concentric disk sampler, bound to the top level.
// ----------------------------------------------------------------------------
`include "concentric_disk_sample_macros.svh"

module cds_checker #(
  parameter int SAMPLE_BITS = cds_pkg::SAMPLE_BITS_DEF
) (
  input logic                   clk,
  input logic                   rst,
  input logic                   start,
  input logic                   busy,
  input logic [SAMPLE_BITS-1:0] sample_u,
  input logic [SAMPLE_BITS-1:0] sample_v,
  input logic                   strobe,
  input logic signed [15:0]     disk_x,
  input logic signed [15:0]     disk_y
);

  localparam logic [SAMPLE_BITS-1:0] HALF = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  logic acc, mid, zero_out;
  assign acc      = start && !busy;
  assign mid      = (sample_u == HALF) && (sample_v == HALF);
  assign zero_out = (disk_x == 16'sd0) && (disk_y == 16'sd0);

  // every accepted transaction returns after the fixed latency
  `CDS_ASSERT(a_latency, acc |-> ##(cds_pkg::LATENCY) strobe, "result missing")
  // no strobe without a matching transaction
  `CDS_ASSERT(a_source, strobe |-> $past(acc, cds_pkg::LATENCY), "spurious result")
  // center of the square maps to the disk origin
  `CDS_ASSERT(a_origin, acc && mid |-> ##(cds_pkg::LATENCY) zero_out, "origin not zero")
  `CDS_ASSERT_ALWAYS(a_reset, $past(rst) |-> !strobe, "strobe after reset")

endmodule

bind concentric_disk_sample cds_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_cds_checker (.*);
